// File: hw/rtl/ssol_pkg.sv
// ----------------------------------------------------------------------------
// ssol_pkg
// Shared types and constants of the open-loop six-step start-up sequencer.
// ----------------------------------------------------------------------------
package ssol_pkg;

  localparam int unsigned TICK_FREQ_HZ_DEF = 20000;

  localparam int unsigned DUTY_W   = 15;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned STAGE_W  = 2;
  localparam int unsigned STGT_W   = 20;
  localparam int unsigned PERIOD_W = 18;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned PP_W     = 5;
  localparam int unsigned DVSR_W   = RPM_W + PP_W;
  localparam int unsigned DIV_STEPS = PERIOD_W;
  localparam int unsigned DCNT_W   = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_DUTY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_SECT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PP_COUNT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 3'd4;

  // stage codes
  localparam logic [STAGE_W-1:0] STG_RESET = 2'd0;
  localparam logic [STAGE_W-1:0] STG_ALIGN = 2'd1;
  localparam logic [STAGE_W-1:0] STG_RAMP  = 2'd2;

  localparam logic [SECTOR_W-1:0] SECTOR_MAX = 3'd5;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [STGT_W-1:0]   STGT_MAX   = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef struct packed {
    logic             command;
    logic [RPM_W-1:0] speed_setpoint_rpm;
  } in_item_t;

  typedef struct packed {
    logic [STAGE_W-1:0]  stage;
    logic [SECTOR_W-1:0] sector;
    logic [DUTY_W-1:0]   duty_q15;
    logic                commutated;
    logic [PERIOD_W-1:0] period_ticks;
    logic [RPM_W-1:0]    latched_rpm;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   align_duty;
    logic [SECTOR_W-1:0] align_sect;
    logic [STGT_W-1:0]   align_ticks;
    logic [PP_W-1:0]     pp_count;
    logic                direction;
  } cfg_regs_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic tick;
    logic div_init;
    logic div_step;
    logic period_load;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic comm_now;
  } dp_status_t;

endpackage

// File: hw/rtl/ssol_datapath.sv
// ----------------------------------------------------------------------------
// ssol_datapath
// Start-up state registers, tick update, multiplier and radix-2 divider for
// the commutation period, and the result register.
// ----------------------------------------------------------------------------
module ssol_datapath #(
  parameter int unsigned TICK_FREQ_HZ = ssol_pkg::TICK_FREQ_HZ_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ssol_pkg::cfg_regs_t cfg,
  input  ssol_pkg::in_item_t  in_data,
  input  ssol_pkg::ctrl_cmd_t cmd,
  output ssol_pkg::dp_status_t status,
  output ssol_pkg::out_item_t out_data
);
  import ssol_pkg::*;

  localparam logic [PERIOD_W-1:0] DIVIDEND = PERIOD_W'(TICK_FREQ_HZ * 10);

  logic                cmd_r, cmd_nxt;
  logic [RPM_W-1:0]    rpm_r, rpm_nxt;
  logic [STAGE_W-1:0]  stage_r, stage_nxt;
  logic [STGT_W-1:0]   se_r, se_nxt;
  logic [PERIOD_W-1:0] ce_r, ce_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [SECTOR_W-1:0] sector_r, sector_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic [RPM_W-1:0]    speed_r, speed_nxt;
  logic                comm_r, comm_nxt;
  logic [DVSR_W-1:0]   dvsr_r, dvsr_nxt;
  logic [DVSR_W:0]     rem_r, rem_nxt;
  logic [PERIOD_W-1:0] quo_r, quo_nxt;
  out_item_t           out_r, out_nxt;

  // tick evaluation
  logic [STGT_W-1:0]   se_inc, se_v;
  logic [PERIOD_W-1:0] ce_inc, ce_v;
  logic                enter_align, in_align, to_ramp, go_ramp, comm;
  logic [SECTOR_W-1:0] sector_v, sector_step, align_sec;
  logic [DVSR_W:0]     rem_sh;

  always_comb begin
    se_inc = (se_r == STGT_MAX) ? se_r : se_r + 1'b1;
    ce_inc = (ce_r == PERIOD_MAX) ? ce_r : ce_r + 1'b1;
    align_sec = (cfg.align_sect > SECTOR_MAX) ? cfg.align_sect - 3'd6 : cfg.align_sect;

    enter_align = (cmd_r == CMD_RESTART) || (stage_r == STG_RESET);
    in_align    = enter_align || (stage_r == STG_ALIGN);
    se_v        = enter_align ? '0 : se_inc;
    sector_v    = enter_align ? align_sec : sector_r;
    to_ramp     = in_align && (se_v >= cfg.align_ticks);
    go_ramp     = to_ramp || (!enter_align && (stage_r == STG_RAMP));
    // entering the ramp restarts the commutation timer
    ce_v        = to_ramp ? '0 : ce_inc;
    comm        = go_ramp && (ce_v >= period_r);

    if (cfg.direction) begin
      sector_step = (sector_v == '0) ? SECTOR_MAX : sector_v - 1'b1;
    end else begin
      sector_step = (sector_v == SECTOR_MAX) ? '0 : sector_v + 1'b1;
    end
  end

  assign status.comm_now = comm;

  always_comb begin
    cmd_nxt    = cmd_r;
    rpm_nxt    = rpm_r;
    stage_nxt  = stage_r;
    se_nxt     = se_r;
    ce_nxt     = ce_r;
    period_nxt = period_r;
    sector_nxt = sector_r;
    duty_nxt   = duty_r;
    speed_nxt  = speed_r;
    comm_nxt   = comm_r;
    dvsr_nxt   = dvsr_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    out_nxt    = out_r;
    rem_sh     = {rem_r[DVSR_W-1:0], quo_r[PERIOD_W-1]};

    if (cmd.capture) begin
      cmd_nxt = in_data.command;
      rpm_nxt = in_data.speed_setpoint_rpm;
    end

    if (cmd.tick) begin
      se_nxt     = to_ramp ? '0 : se_v;
      ce_nxt     = comm ? '0 : ce_v;
      sector_nxt = comm ? sector_step : sector_v;
      comm_nxt   = comm;
      if (enter_align) begin
        duty_nxt  = cfg.align_duty;
        stage_nxt = STG_ALIGN;
      end
      if (to_ramp) begin
        stage_nxt = STG_RAMP;
      end
      if (comm) begin
        speed_nxt = rpm_r;
      end
    end

    // a zero divisor yields an all-ones quotient, which is the saturated period
    if (cmd.div_init) begin
      dvsr_nxt = DVSR_W'(rpm_r) * DVSR_W'(cfg.pp_count);
      rem_nxt  = '0;
      quo_nxt  = DIVIDEND;
    end

    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvsr_r}) begin
        rem_nxt = rem_sh - {1'b0, dvsr_r};
        quo_nxt = {quo_r[PERIOD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[PERIOD_W-2:0], 1'b0};
      end
    end

    if (cmd.period_load) begin
      period_nxt = quo_r;
    end

    if (cmd.out_load) begin
      out_nxt.stage        = stage_r;
      out_nxt.sector       = sector_r;
      out_nxt.duty_q15     = duty_r;
      out_nxt.commutated   = comm_r;
      out_nxt.period_ticks = period_r;
      out_nxt.latched_rpm  = speed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r  <= STG_RESET;
      se_r     <= '0;
      ce_r     <= '0;
      period_r <= '0;
      sector_r <= '0;
      duty_r   <= '0;
      speed_r  <= '0;
    end else begin
      stage_r  <= stage_nxt;
      se_r     <= se_nxt;
      ce_r     <= ce_nxt;
      period_r <= period_nxt;
      sector_r <= sector_nxt;
      duty_r   <= duty_nxt;
      speed_r  <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    rpm_r  <= rpm_nxt;
    comm_r <= comm_nxt;
    dvsr_r <= dvsr_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// File: hw/rtl/ssol_ctrl.sv
// ----------------------------------------------------------------------------
// ssol_ctrl
// Sequencer: take one transaction, evaluate the tick, run the period
// divider on a commutation, then hand the result to the output register.
// ----------------------------------------------------------------------------
module ssol_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ssol_pkg::dp_status_t status,
  output ssol_pkg::ctrl_cmd_t  cmd
);
  import ssol_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [DCNT_W-1:0] CNT_LAST = DCNT_W'(DIV_STEPS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              ovld_r, ovld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r && !out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_TICK;
        end
      end
      S_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = status.comm_now ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.period_load = 1'b1;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ovld_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

// File: hw/rtl/six_step_open_loop_startup.sv
// ----------------------------------------------------------------------------
// six_step_open_loop_startup
// Open-loop six-step motor start-up sequencer, one transaction per PWM tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one transaction per PWM
//   tick: command 0 advances one tick, command 1 restarts the start-up
//   (align, then ramp) and then ticks. Output channel (out_valid/out_ready/
//   out_data) returns exactly one transaction per input transaction with
//   stage, sector, duty, commutation flag, period and latched speed.
//   Configuration: write cfg_wdata to register cfg_index while cfg_wr_en is
//   high; write only while no tick is in flight.
//   Commutation: a tick with a commutation adds the divisor setup, the
//   18-step restoring divider that computes the new commutation period one
//   quotient bit a cycle, and the period write-back before the result.
//   One tick is processed at a time: a new transaction is not accepted
//   until the result of the last one is in the output register.
//   Reset: synchronous, active low; clears the sequencer to the reset stage
//   and the control, start-up state and configuration registers to their
//   reset values (pole pair count to 1), but not the data registers.
//   Stall: a finished result waits in the output register; the next input
//   transaction is still accepted and processed, then holds until the
//   output register is taken.
// ----------------------------------------------------------------------------
module six_step_open_loop_startup #(
  parameter int unsigned TICK_FREQ_HZ = ssol_pkg::TICK_FREQ_HZ_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ssol_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ssol_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [ssol_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssol_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ssol_pkg::*;

  cfg_regs_t  cfg_r, cfg_nxt;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_ALIGN_DUTY:   cfg_nxt.align_duty   = cfg_wdata[DUTY_W-1:0];
        REG_ALIGN_SECT:   cfg_nxt.align_sect   = cfg_wdata[SECTOR_W-1:0];
        REG_ALIGN_TICKS:  cfg_nxt.align_ticks  = cfg_wdata[STGT_W-1:0];
        REG_PP_COUNT:     cfg_nxt.pp_count     = cfg_wdata[PP_W-1:0];
        REG_DIRECTION:    cfg_nxt.direction    = cfg_wdata[0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.align_duty   <= '0;
      cfg_r.align_sect   <= '0;
      cfg_r.align_ticks  <= '0;
      cfg_r.pp_count     <= PP_W'(1);
      cfg_r.direction    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssol_datapath #(
    .TICK_FREQ_HZ (TICK_FREQ_HZ)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// File: hw/rtl/ssol_checker.sv
// ----------------------------------------------------------------------------
// ssol_checker
// Port-level checks of the start-up sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ssol_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ssol_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ssol_pkg::out_item_t out_data
);
  import ssol_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // one tick in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  a_stage_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.stage == STG_ALIGN) || (out_data.stage == STG_RAMP))
    else $error("result reports reset stage");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sector <= SECTOR_MAX)
    else $error("sector out of range");

  a_comm_in_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.commutated |-> out_data.stage == STG_RAMP)
    else $error("commutation outside ramp");

endmodule

bind six_step_open_loop_startup ssol_checker u_ssol_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: bench/ssol_startup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssol_startup_checker
// Passive checker for the six-step start-up sequencer: mirrors the register
// writes, predicts the result of every accepted tick and compares it field by
// field with the result transactions in order.
// ----------------------------------------------------------------------------
module ssol_startup_checker #(
  parameter int unsigned TICK_FREQ_HZ = ssol_pkg::TICK_FREQ_HZ_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ssol_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ssol_pkg::out_item_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [ssol_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssol_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     n_fail,
  output int unsigned                     n_pending,
  output int unsigned                     n_checked,
  output int unsigned                     n_comm
);
  import ssol_pkg::*;

  localparam int unsigned MAX_REPORTS = 200;

  cfg_regs_t             regs;
  logic [STAGE_W-1:0]    stg_now;
  logic [STAGE_W-1:0]    stg_prev;
  logic [STGT_W-1:0]     stg_elapsed;
  logic [PERIOD_W-1:0]   comm_elapsed;
  logic [PERIOD_W-1:0]   comm_period;
  logic [SECTOR_W-1:0]   sector_now;
  logic [DUTY_W-1:0]     duty_now;
  logic [RPM_W-1:0]      speed_held;
  out_item_t             expected_outputs[$];
  int unsigned           n_reports;

  // Advance the sequencer by one PWM tick and return the outputs after it.
  function automatic out_item_t advance_sequencer(in_item_t tick_in);
    out_item_t   res;
    logic        comm;
    logic        in_ramp;
    int unsigned rpm_u;
    int unsigned pp_u;
    int unsigned dvsr;
    int unsigned quot;
    comm    = 1'b0;
    in_ramp = 1'b0;
    if (stg_elapsed != STGT_MAX) stg_elapsed = stg_elapsed + 1'b1;
    if (comm_elapsed != PERIOD_MAX) comm_elapsed = comm_elapsed + 1'b1;
    if (tick_in.command == CMD_RESTART) stg_now = STG_RESET;
    if (stg_now == STG_RESET) begin
      stg_prev = STG_RESET;
      stg_now  = STG_ALIGN;
    end
    if (stg_now == STG_ALIGN) begin
      if (stg_now != stg_prev) begin
        duty_now    = regs.align_duty;
        // out-of-range align sectors wrap back into 0..5
        sector_now  = (regs.align_sect > SECTOR_MAX) ? regs.align_sect - 3'd6
                                                     : regs.align_sect;
        stg_elapsed = '0;
        stg_prev    = STG_ALIGN;
      end
      if (stg_elapsed >= regs.align_ticks) begin
        stg_now = STG_RAMP;
        in_ramp = 1'b1;
      end
    end else if (stg_now == STG_RAMP) begin
      in_ramp = 1'b1;
    end
    if (in_ramp) begin
      if (stg_now != stg_prev) begin
        stg_elapsed  = '0;
        comm_elapsed = '0;
        stg_prev     = STG_RAMP;
      end
      if (comm_elapsed >= comm_period) begin
        comm       = 1'b1;
        speed_held = tick_in.speed_setpoint_rpm;
        rpm_u      = tick_in.speed_setpoint_rpm;
        pp_u       = regs.pp_count;
        dvsr       = rpm_u * pp_u;
        if (dvsr == 0) begin
          comm_period = PERIOD_MAX;
        end else begin
          quot        = (TICK_FREQ_HZ * 10) / dvsr;
          comm_period = (quot > PERIOD_MAX) ? PERIOD_MAX : quot[PERIOD_W-1:0];
        end
        if (regs.direction) begin
          sector_now = (sector_now == '0) ? SECTOR_MAX : sector_now - 3'd1;
        end else begin
          sector_now = (sector_now == SECTOR_MAX) ? '0 : sector_now + 3'd1;
        end
        comm_elapsed = '0;
      end
    end
    res.stage        = stg_now;
    res.sector       = sector_now;
    res.duty_q15     = duty_now;
    res.commutated   = comm;
    res.period_ticks = comm_period;
    res.latched_rpm  = speed_held;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got, inout int unsigned errs);
    if (want != got) begin
      errs++;
      if (n_reports < MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
      n_reports++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t   want;
    out_item_t   got;
    int unsigned errs;
    if (!rst_n) begin
      regs.align_duty   = '0;
      regs.align_sect   = '0;
      regs.align_ticks  = '0;
      regs.pp_count     = PP_W'(1);
      regs.direction    = 1'b0;
      stg_now      = STG_RESET;
      stg_prev     = STG_RESET;
      stg_elapsed  = '0;
      comm_elapsed = '0;
      comm_period  = '0;
      sector_now   = '0;
      duty_now     = '0;
      speed_held   = '0;
      expected_outputs.delete();
      n_reports    = 0;
      n_fail    <= 0;
      n_pending <= 0;
      n_checked <= 0;
      n_comm    <= 0;
    end else begin
      errs = 0;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ALIGN_DUTY:   regs.align_duty   = cfg_wdata[DUTY_W-1:0];
          REG_ALIGN_SECT:   regs.align_sect   = cfg_wdata[SECTOR_W-1:0];
          REG_ALIGN_TICKS:  regs.align_ticks  = cfg_wdata[STGT_W-1:0];
          REG_PP_COUNT:     regs.pp_count     = cfg_wdata[PP_W-1:0];
          REG_DIRECTION:    regs.direction    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_outputs.size() == 0) begin
          errs++;
          if (n_reports < MAX_REPORTS)
            $error("result: none expected, got stage %0d sector %0d", got.stage, got.sector);
          n_reports++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("stage", want.stage, got.stage, errs);
          check_field("sector", want.sector, got.sector, errs);
          check_field("duty_q15", want.duty_q15, got.duty_q15, errs);
          check_field("commutated", want.commutated, got.commutated, errs);
          check_field("period_ticks", want.period_ticks, got.period_ticks, errs);
          check_field("latched_rpm", want.latched_rpm, got.latched_rpm, errs);
          n_checked <= n_checked + 1;
          if (want.commutated) n_comm <= n_comm + 1;
        end
      end
      if (in_valid && in_ready) expected_outputs.push_back(advance_sequencer(in_data));
      n_fail    <= n_fail + errs;
      n_pending <= expected_outputs.size();
    end
  end

endmodule

// File: bench/six_step_open_loop_startup_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_step_open_loop_startup_tb
// Drives PWM tick transactions and register settings into the start-up
// sequencer: a directed pass over align, ramp entry and wrap cases, then
// random ticks under three pacing mixes, ending with a zero divisor.
// ----------------------------------------------------------------------------
module six_step_open_loop_startup_tb;
  import ssol_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned SEG_ITEMS    = 115;
  localparam int unsigned ZERO_ITEMS   = 220;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned n_comm;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned n_settings   = 0;
  int unsigned cycles       = 0;

  six_step_open_loop_startup u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssol_startup_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked),
    .n_comm    (n_comm)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout: %0d result transactions still expected", n_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one tick and hold it until the transaction is taken.
  task automatic send_tick(input logic cmd, input logic [RPM_W-1:0] rpm);
    in_item_t item;
    item.command            = cmd;
    item.speed_setpoint_rpm = rpm;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic write_regs(input cfg_regs_t regs);
    drain();
    put_reg(REG_ALIGN_DUTY, CFG_DATA_W'(regs.align_duty));
    put_reg(REG_ALIGN_SECT, CFG_DATA_W'(regs.align_sect));
    put_reg(REG_ALIGN_TICKS, CFG_DATA_W'(regs.align_ticks));
    put_reg(REG_PP_COUNT, CFG_DATA_W'(regs.pp_count));
    put_reg(REG_DIRECTION, CFG_DATA_W'(regs.direction));
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  function automatic cfg_regs_t make_regs(input logic [DUTY_W-1:0] duty,
                                          input logic [SECTOR_W-1:0] sec,
                                          input logic [STGT_W-1:0] ticks,
                                          input logic [PP_W-1:0] pp,
                                          input logic dir);
    cfg_regs_t regs;
    regs.align_duty   = duty;
    regs.align_sect   = sec;
    regs.align_ticks  = ticks;
    regs.pp_count     = pp;
    regs.direction    = dir;
    return regs;
  endfunction

  function automatic cfg_regs_t random_regs();
    logic [DUTY_W-1:0] duty;
    logic [STGT_W-1:0] ticks;
    case ($urandom_range(3))
      0:       duty = '0;
      1:       duty = '1;
      default: duty = DUTY_W'($urandom_range(32767));
    endcase
    ticks = ($urandom_range(3) == 0) ? '0 : STGT_W'($urandom_range(12, 1));
    return make_regs(duty, SECTOR_W'($urandom_range(7)), ticks,
                     PP_W'($urandom_range(31, 1)), 1'($urandom_range(1)));
  endfunction

  // Keep rpm times pole pairs large enough that the period stays short.
  function automatic logic [RPM_W-1:0] random_rpm();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return RPM_W'($urandom_range(65535, 6000));
    if (pick < 85) return RPM_W'($urandom_range(5999, 2000));
    return RPM_W'($urandom_range(1999, 1000));
  endfunction

  initial begin : stimulus
    int unsigned mode;
    int unsigned seg;
    int unsigned k;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero align time, first ramp tick commutates at once
    send_tick(CMD_TICK, 16'hFFFF);
    send_tick(CMD_TICK, 16'd40000);
    send_tick(CMD_TICK, 16'd20000);
    send_tick(CMD_TICK, 16'hFFFF);

    // full duty, align sector 7 wraps to 1, counting down, max pole pairs
    write_regs(make_regs('1, 3'd7, 20'd3, 5'd31, 1'b1));
    send_tick(CMD_RESTART, 16'd0);
    send_tick(CMD_TICK, 16'd0);
    send_tick(CMD_TICK, 16'hAAAA);
    send_tick(CMD_TICK, 16'h5555);
    send_tick(CMD_TICK, 16'd1000);
    send_tick(CMD_TICK, 16'd2000);
    send_tick(CMD_TICK, 16'd5000);
    send_tick(CMD_TICK, 16'd3000);

    // longest align time, restart inside align, then shorten it while idle
    write_regs(make_regs('0, 3'd6, STGT_MAX, 5'd16, 1'b0));
    send_tick(CMD_RESTART, 16'hFFFF);
    send_tick(CMD_TICK, 16'd0);
    send_tick(CMD_RESTART, 16'd0);
    send_tick(CMD_TICK, 16'd0);
    write_regs(make_regs('0, 3'd6, 20'd2, 5'd16, 1'b0));
    send_tick(CMD_TICK, 16'd50000);
    send_tick(CMD_TICK, 16'd50000);
    send_tick(CMD_TICK, 16'd50000);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle_pct = 28;
          rcv_idle_pct = 64;
        end
        1: begin
          snd_idle_pct = 64;
          rcv_idle_pct = 28;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        write_regs(random_regs());
        for (k = 0; k < SEG_ITEMS; k++)
          send_tick(($urandom_range(99) < 4) ? CMD_RESTART : CMD_TICK, random_rpm());
      end
    end

    // zero pole pairs: the next commutation saturates the period for good
    write_regs(make_regs(DUTY_W'($urandom_range(32767)), 3'd5, '0, 5'd0, 1'b1));
    for (k = 0; k < ZERO_ITEMS; k++)
      send_tick((k == 0) ? CMD_RESTART : CMD_TICK,
                (k % 2 == 1) ? 16'd0 : RPM_W'($urandom_range(65535)));

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d tick transactions with %0d commutations over %0d register settings,",
             n_checked, n_comm, n_settings);
    $display("under three handshake pacing mixes, align/ramp restarts and a zero divisor.");
    if (n_fail == 0 && n_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
